>>> src/hipt_pkg.sv
// ----------------------------------------------------------------------------
// hipt_pkg
// shared types and constants of the hashed inverted page table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hipt_pkg;

  localparam int NUM_LINES    = 64;
  localparam int ANCHOR_SLOTS = 64;
  localparam int LINE_W       = $clog2(NUM_LINES);
  localparam int PTR_W        = LINE_W + 1;
  localparam int ANCHOR_W     = $clog2(ANCHOR_SLOTS);
  localparam int PROC_W       = 8;
  localparam int PAGE_W       = 16;
  localparam int FRAME_W      = 7;
  localparam int CMD_W        = 3;
  localparam int CNT_W        = LINE_W + 1;
  localparam int IN_TDATA_W   = 48;
  localparam int OUT_TDATA_W  = 16;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [PTR_W-1:0]   NONE_PTR   = {PTR_W{1'b1}};
  localparam logic [FRAME_W-1:0] NONE_FRAME = {FRAME_W{1'b1}};
  localparam logic [LINE_W-1:0]  LAST_LINE  = LINE_W'(NUM_LINES - 1);
  localparam logic [CNT_W-1:0]   LINE_COUNT = CNT_W'(NUM_LINES);

  typedef enum logic [CMD_W-1:0] {
    OP_ADD           = 3'd0,
    OP_LOOKUP        = 3'd1,
    OP_REMOVE        = 3'd2,
    OP_FREE_FRAME    = 3'd3,
    OP_LINE_BY_FRAME = 3'd4,
    OP_SET_DIRTY     = 3'd5,
    OP_SET_REF       = 3'd6,
    OP_NONE          = 3'd7
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [ANCHOR_W-1:0] anchor_index;
    logic [PROC_W-1:0]   process_id;
    logic [PAGE_W-1:0]   page_number;
    logic [FRAME_W-1:0]  frame_number;
    logic [LINE_W-1:0]   line_index;
    logic                bit_value;
  } cmd_t;

  typedef struct packed {
    logic [PROC_W-1:0]  process_id;
    logic [PAGE_W-1:0]  page_number;
    logic [FRAME_W-1:0] frame_number;
  } line_data_t;

  typedef struct packed {
    logic               ok;
    logic [FRAME_W-1:0] frame_out;
    logic [PTR_W-1:0]   line_out;
  } res_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

`default_nettype wire

>>> src/hipt_front.sv
// ----------------------------------------------------------------------------
// hipt_front
// accepts input transactions, unpacks them and classifies the command
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hipt_front (
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [hipt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  wire logic                               push_ready_i,
  output logic                                    push_valid_o,
  output hipt_pkg::cmd_t                          push_cmd_o
);

  logic [hipt_pkg::CMD_W-1:0] command;

  assign command       = s_axis_tdata[2:0];
  assign s_axis_tready = push_ready_i;
  assign push_valid_o  = s_axis_tvalid;

  always_comb begin
    push_cmd_o.anchor_index = s_axis_tdata[8:3];
    push_cmd_o.process_id   = s_axis_tdata[16:9];
    push_cmd_o.page_number  = s_axis_tdata[32:17];
    push_cmd_o.frame_number = s_axis_tdata[39:33];
    push_cmd_o.line_index   = s_axis_tdata[45:40];
    push_cmd_o.bit_value    = s_axis_tdata[46];
    // every 3-bit command code is an op_e member, code 7 is OP_NONE
    push_cmd_o.op           = hipt_pkg::op_e'(command);
  end

endmodule

`default_nettype wire

>>> src/hipt_queue.sv
// ----------------------------------------------------------------------------
// hipt_queue
// short command queue between the front and the table engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hipt_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  input  wire hipt_pkg::cmd_t push_cmd_i,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i,
  output hipt_pkg::cmd_t      pop_cmd_o
);

  localparam int PW = $clog2(hipt_pkg::QUEUE_DEPTH);

  hipt_pkg::cmd_t entry_q [hipt_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PW:0]    count_q;
  logic           push, pop;

  assign push_ready_o = count_q != (PW+1)'(hipt_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        entry_q[wr_ptr_q] <= push_cmd_i;
        wr_ptr_q          <= wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + (PW+1)'(1);
      end else if (pop && !push) begin
        count_q <= count_q - (PW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> src/hipt_engine.sv
// ----------------------------------------------------------------------------
// hipt_engine
// table engine: line memories, anchor memory, chain walks and scans
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hipt_engine (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  output logic                cmd_ready_o,
  input  wire hipt_pkg::cmd_t cmd_i,
  output logic                res_valid_o,
  input  wire logic           res_ready_i,
  output hipt_pkg::res_t      res_o
);

  localparam int LW = hipt_pkg::LINE_W;
  localparam int PW = hipt_pkg::PTR_W;
  localparam int CW = hipt_pkg::CNT_W;
  localparam int NL = hipt_pkg::NUM_LINES;
  localparam int NA = hipt_pkg::ANCHOR_SLOTS;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_SCAN,
    S_ADD_WRITE,
    S_ADD_HEAD,
    S_ADD_WALK,
    S_LK_HEAD,
    S_LK_NODE,
    S_RM_LINK,
    S_RM_CLEAR,
    S_FF_SCAN,
    S_FF_PICK,
    S_LF_SCAN,
    S_DONE
  } state_e;

  function automatic logic live(input logic [PW-1:0] p, input logic [NL-1:0] used);
    return !p[PW-1] && used[p[LW-1:0]];
  endfunction

  hipt_pkg::line_data_t data_mem [NL];
  logic [PW-1:0]        next_mem [NL];
  logic [PW-1:0]        prev_mem [NL];
  logic [PW-1:0]        anchor_mem [NA];
  logic                 dirty_mem [NL];
  logic                 ref_mem [NL];

  state_e               state_q, state_d;
  hipt_pkg::cmd_t       cur_q, cur_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic [CW-1:0]        steps_q, steps_d;
  logic [LW-1:0]        line_q, line_d;
  logic [PW-1:0]        ptr_q, ptr_d;
  logic [NL-1:0]        used_q, used_d;
  logic [NA-1:0]        avld_q, avld_d;
  logic [NL-1:0]        taken_q, taken_d;
  logic                 scan_vld_q, scan_vld_d;
  logic [LW-1:0]        scan_idx_q, scan_idx_d;
  hipt_pkg::res_t       res_q, res_d, out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  hipt_pkg::line_data_t data_rd_q, data_wd;
  logic [PW-1:0]        next_rd_q, prev_rd_q, anc_rd_q;
  logic [PW-1:0]        next_wd, prev_wd, anc_wd;
  logic [LW-1:0]        data_ra, data_wa, next_ra, next_wa, prev_ra, prev_wa;
  logic [hipt_pkg::ANCHOR_W-1:0] anc_ra;
  logic                 data_we, next_we, prev_we, anc_we, dirty_we, ref_we;
  logic                 flag_wd;

  logic [PW-1:0]        head, nx, pv;
  logic [CW-1:0]        steps_n;
  hipt_pkg::res_t       fail;

  assign cmd_ready_o = state_q == S_IDLE;
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;
  assign fail        = '{ok: 1'b0, frame_out: hipt_pkg::NONE_FRAME,
                         line_out: hipt_pkg::NONE_PTR};
  assign head        = avld_q[cur_q.anchor_index] ? anc_rd_q : hipt_pkg::NONE_PTR;
  assign nx          = next_rd_q;
  assign pv          = prev_rd_q;
  assign steps_n     = steps_q + CW'(1);
  assign anc_ra      = (state_q == S_IDLE) ? cmd_i.anchor_index : cur_q.anchor_index;

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    steps_d     = steps_q;
    line_d      = line_q;
    ptr_d       = ptr_q;
    used_d      = used_q;
    avld_d      = avld_q;
    taken_d     = taken_q;
    scan_vld_d  = 1'b0;
    scan_idx_d  = scan_idx_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !res_ready_i;

    data_we  = 1'b0;
    data_wa  = line_q;
    data_wd  = '{process_id: cur_q.process_id, page_number: cur_q.page_number,
                 frame_number: cur_q.frame_number};
    data_ra  = idx_q[LW-1:0];
    next_we  = 1'b0;
    next_wa  = line_q;
    next_wd  = hipt_pkg::NONE_PTR;
    next_ra  = (state_q == S_IDLE) ? cmd_i.line_index : ptr_q[LW-1:0];
    prev_we  = 1'b0;
    prev_wa  = line_q;
    prev_wd  = hipt_pkg::NONE_PTR;
    prev_ra  = (state_q == S_IDLE) ? cmd_i.line_index : ptr_q[LW-1:0];
    anc_we   = 1'b0;
    anc_wd   = hipt_pkg::NONE_PTR;
    dirty_we = 1'b0;
    ref_we   = 1'b0;
    flag_wd  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cur_d = cmd_i;
          idx_d = '0;
          res_d = fail;
          unique case (cmd_i.op)
            hipt_pkg::OP_ADD:        state_d = S_ADD_SCAN;
            hipt_pkg::OP_LOOKUP:     state_d = S_LK_HEAD;
            hipt_pkg::OP_REMOVE:     state_d = S_RM_LINK;
            hipt_pkg::OP_FREE_FRAME: begin
              taken_d = '0;
              state_d = S_FF_SCAN;
            end
            hipt_pkg::OP_LINE_BY_FRAME,
            hipt_pkg::OP_SET_DIRTY,
            hipt_pkg::OP_SET_REF:    state_d = S_LF_SCAN;
            default:                 state_d = S_DONE;
          endcase
        end
      end

      S_ADD_SCAN: begin
        if (!used_q[idx_q[LW-1:0]]) begin
          line_d  = idx_q[LW-1:0];
          state_d = S_ADD_WRITE;
        end else if (idx_q[LW-1:0] == hipt_pkg::LAST_LINE) begin
          state_d = S_DONE;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end

      S_ADD_WRITE: begin
        data_we  = 1'b1;
        next_we  = 1'b1;
        prev_we  = 1'b1;
        dirty_we = 1'b1;
        ref_we   = 1'b1;
        used_d[line_q] = 1'b1;
        state_d  = S_ADD_HEAD;
      end

      S_ADD_HEAD: begin
        if (!live(head, used_q)) begin
          anc_we  = 1'b1;
          anc_wd  = {1'b0, line_q};
          avld_d[cur_q.anchor_index] = 1'b1;
          res_d   = '{ok: 1'b1, frame_out: hipt_pkg::NONE_FRAME,
                      line_out: {1'b0, line_q}};
          state_d = S_DONE;
        end else begin
          ptr_d   = head;
          steps_d = '0;
          next_ra = head[LW-1:0];
          state_d = S_ADD_WALK;
        end
      end

      S_ADD_WALK: begin
        if (steps_q < hipt_pkg::LINE_COUNT && live(nx, used_q)) begin
          ptr_d   = nx;
          steps_d = steps_n;
          next_ra = nx[LW-1:0];
        end else begin
          next_we = 1'b1;
          next_wa = ptr_q[LW-1:0];
          next_wd = {1'b0, line_q};
          prev_we = 1'b1;
          prev_wd = ptr_q;
          res_d   = '{ok: 1'b1, frame_out: hipt_pkg::NONE_FRAME,
                      line_out: {1'b0, line_q}};
          state_d = S_DONE;
        end
      end

      S_LK_HEAD: begin
        if (live(head, used_q)) begin
          ptr_d   = head;
          steps_d = '0;
          data_ra = head[LW-1:0];
          next_ra = head[LW-1:0];
          state_d = S_LK_NODE;
        end else begin
          state_d = S_DONE;
        end
      end

      S_LK_NODE: begin
        if (data_rd_q.process_id == cur_q.process_id &&
            data_rd_q.page_number == cur_q.page_number) begin
          res_d   = '{ok: 1'b1, frame_out: data_rd_q.frame_number,
                      line_out: hipt_pkg::NONE_PTR};
          state_d = S_DONE;
        end else if (steps_n <= hipt_pkg::LINE_COUNT && live(nx, used_q)) begin
          ptr_d   = nx;
          steps_d = steps_n;
          data_ra = nx[LW-1:0];
          next_ra = nx[LW-1:0];
        end else begin
          state_d = S_DONE;
        end
      end

      S_RM_LINK: begin
        line_d = cur_q.line_index;
        if (!used_q[cur_q.line_index]) begin
          state_d = S_DONE;
        end else begin
          if (live(pv, used_q)) begin
            next_we = 1'b1;
            next_wa = pv[LW-1:0];
            next_wd = nx;
          end else begin
            anc_we = 1'b1;
            anc_wd = nx;
            avld_d[cur_q.anchor_index] = 1'b1;
          end
          if (live(nx, used_q)) begin
            prev_we = 1'b1;
            prev_wa = nx[LW-1:0];
            prev_wd = live(pv, used_q) ? pv : hipt_pkg::NONE_PTR;
          end
          state_d = S_RM_CLEAR;
        end
      end

      S_RM_CLEAR: begin
        used_d[line_q] = 1'b0;
        next_we = 1'b1;
        prev_we = 1'b1;
        res_d   = '{ok: 1'b1, frame_out: hipt_pkg::NONE_FRAME,
                    line_out: hipt_pkg::NONE_PTR};
        state_d = S_DONE;
      end

      S_FF_SCAN: begin
        if (!idx_q[CW-1]) begin
          scan_vld_d = 1'b1;
          scan_idx_d = idx_q[LW-1:0];
          idx_d      = idx_q + CW'(1);
        end
        if (scan_vld_q && used_q[scan_idx_q] && !data_rd_q.frame_number[hipt_pkg::FRAME_W-1]) begin
          taken_d[data_rd_q.frame_number[LW-1:0]] = 1'b1;
        end
        if (scan_vld_q && scan_idx_q == hipt_pkg::LAST_LINE) begin
          idx_d   = '0;
          state_d = S_FF_PICK;
        end
      end

      S_FF_PICK: begin
        if (!taken_q[idx_q[LW-1:0]]) begin
          res_d   = '{ok: 1'b1, frame_out: hipt_pkg::FRAME_W'(idx_q[LW-1:0]),
                      line_out: hipt_pkg::NONE_PTR};
          state_d = S_DONE;
        end else if (idx_q[LW-1:0] == hipt_pkg::LAST_LINE) begin
          state_d = S_DONE;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end

      S_LF_SCAN: begin
        if (!idx_q[CW-1]) begin
          scan_vld_d = 1'b1;
          scan_idx_d = idx_q[LW-1:0];
          idx_d      = idx_q + CW'(1);
        end
        if (scan_vld_q && used_q[scan_idx_q] &&
            data_rd_q.frame_number == cur_q.frame_number) begin
          line_d   = scan_idx_q;
          flag_wd  = cur_q.bit_value;
          dirty_we = cur_q.op == hipt_pkg::OP_SET_DIRTY;
          ref_we   = cur_q.op == hipt_pkg::OP_SET_REF;
          data_wa  = scan_idx_q;
          res_d    = '{ok: 1'b1, frame_out: hipt_pkg::NONE_FRAME,
                       line_out: {1'b0, scan_idx_q}};
          state_d  = S_DONE;
        end else if (scan_vld_q && scan_idx_q == hipt_pkg::LAST_LINE) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || res_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      avld_q      <= '0;
      taken_q     <= '0;
      scan_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      avld_q      <= avld_d;
      taken_q     <= taken_d;
      scan_vld_q  <= scan_vld_d;
      out_valid_q <= out_valid_d;
      cur_q       <= cur_d;
      idx_q       <= idx_d;
      steps_q     <= steps_d;
      line_q      <= line_d;
      ptr_q       <= ptr_d;
      scan_idx_q  <= scan_idx_d;
      res_q       <= res_d;
      out_q       <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_we) begin
      data_mem[data_wa] <= data_wd;
    end
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (anc_we) begin
      anchor_mem[cur_q.anchor_index] <= anc_wd;
    end
    if (dirty_we) begin
      dirty_mem[data_wa] <= flag_wd;
    end
    if (ref_we) begin
      ref_mem[data_wa] <= flag_wd;
    end
    data_rd_q <= data_mem[data_ra];
    next_rd_q <= next_mem[next_ra];
    prev_rd_q <= prev_mem[prev_ra];
    anc_rd_q  <= anchor_mem[anc_ra];
  end

endmodule

`default_nettype wire

>>> src/hashed_inverted_page_table.sv
// ----------------------------------------------------------------------------
// hashed_inverted_page_table
// inverted page table with hash anchor chains, stream command interface
// ----------------------------------------------------------------------------
// One command per input transaction, one result transaction per command.
// A two-entry queue sits between the input and the table engine, so the
// input keeps taking commands while the engine works, until the queue is
// full. The engine handles one command at a time over line memories with
// separate read and write ports and registered reads: add scans for the
// lowest free line and then walks the chain to reach the tail; lookup walks
// the chain node by node; remove unlinks and then clears the line; find
// free frame sweeps all lines and then the frame map; line by frame, set
// dirty and set referenced sweep the lines until the first hit.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hashed_inverted_page_table (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // command, anchor_index, process_id, page_number, frame_number,
  // line_index, bit_value
  input  wire logic [hipt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // ok, frame_out, line_out
  output logic [hipt_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);

  hipt_pkg::hs_t  push_hs, pop_hs;
  hipt_pkg::cmd_t push_cmd, pop_cmd;
  hipt_pkg::res_t res;

  hipt_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .push_ready_i  (push_hs.ready),
    .push_valid_o  (push_hs.valid),
    .push_cmd_o    (push_cmd)
  );

  hipt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_hs.valid),
    .push_ready_o (push_hs.ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_hs.valid),
    .pop_ready_i  (pop_hs.ready),
    .pop_cmd_o    (pop_cmd)
  );

  hipt_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_hs.valid),
    .cmd_ready_o (pop_hs.ready),
    .cmd_i       (pop_cmd),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {1'b0, res.line_out, res.frame_out, res.ok};

`ifndef SYNTHESIS
  a_fail_no_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |->
      m_axis_tdata[7:1] == hipt_pkg::NONE_FRAME &&
      m_axis_tdata[14:8] == hipt_pkg::NONE_PTR)
    else $error("failed result carries a frame or line");
  a_ok_one_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |->
      m_axis_tdata[7:1] == hipt_pkg::NONE_FRAME ||
      m_axis_tdata[14:8] == hipt_pkg::NONE_PTR)
    else $error("result carries both a frame and a line");
  a_stall_needs_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> pop_hs.valid)
    else $error("input stalled with an empty queue");
`endif

endmodule

`default_nettype wire
